// ===== rtl/core/e2bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// e2bcd_pkg
// Shared widths, constants and small helpers for the seconds to BCD
// calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package e2bcd_pkg;

  localparam int OP_W      = 18;
  localparam int IN_W      = 32;
  localparam int TOD_W     = 17;
  localparam int DAYS_W    = 16;

  // 86400 = 675 << 7, day count is (t >> 7) / 675 by reciprocal multiply
  localparam int DAY_SHIFT   = 7;
  localparam int NUM_W       = IN_W - DAY_SHIFT;
  localparam int ODD_W       = 10;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 35;
  localparam int PROD_W      = NUM_W + RECIP_W;

  localparam logic [ODD_W-1:0]   DAY_ODD   = 10'd675;
  localparam logic [RECIP_W-1:0] DAY_RECIP = 26'd50903317;

  // day count / 7 by reciprocal multiply for the weekday
  localparam int WK_RECIP_W = 17;
  localparam int WK_SHIFT   = 19;
  localparam int WK_PROD_W  = DAYS_W + WK_RECIP_W;
  localparam int WKQ_W      = WK_PROD_W - WK_SHIFT;

  localparam logic [WK_RECIP_W-1:0] WK_RECIP = 17'd74899;

  localparam logic [OP_W-1:0] SECS_PER_DAY   = 18'd86400;
  localparam logic [OP_W-1:0] DAYS_IN_WINDOW = 18'd36525;
  localparam logic [OP_W-1:0] SECS_10_HOURS  = 18'd36000;
  localparam logic [OP_W-1:0] SECS_PER_HOUR  = 18'd3600;
  localparam logic [OP_W-1:0] SECS_10_MINS   = 18'd600;
  localparam logic [OP_W-1:0] SECS_PER_MIN   = 18'd60;
  localparam logic [OP_W-1:0] SECS_TEN       = 18'd10;
  localparam logic [OP_W-1:0] DAYS_YEAR      = 18'd365;
  localparam logic [OP_W-1:0] DAYS_LEAP_YEAR = 18'd366;

  localparam logic [3:0] FIRST_YEAR_TENS  = 4'd7;
  localparam logic [3:0] FIRST_YEAR_UNITS = 4'd0;
  localparam logic [1:0] FIRST_YEAR_MOD4  = 2'd2;
  localparam logic [3:0] LAST_MONTH       = 4'd11;
  localparam logic [2:0] EPOCH_WEEKDAY    = 3'd4;

  // operands of the shared subtract and compare unit
  typedef struct packed {
    logic [OP_W-1:0] a;
    logic [OP_W-1:0] b;
  } sub_req_t;

  typedef struct packed {
    logic [OP_W-1:0] diff;
    logic            ge;
  } sub_rsp_t;

  function automatic logic [OP_W-1:0] month_len(input logic [3:0] mon, input logic leap);
    logic [OP_W-1:0] len;
    case (mon)
      4'd1:    len = leap ? 18'd29 : 18'd28;
      4'd3:    len = 18'd30;
      4'd5:    len = 18'd30;
      4'd8:    len = 18'd30;
      4'd10:   len = 18'd30;
      default: len = 18'd31;
    endcase
    return len;
  endfunction

  // two BCD digits for a value below 32
  function automatic logic [5:0] small_bcd(input logic [4:0] v);
    logic [5:0] r;
    if (v >= 5'd30) begin
      r = {2'd3, 4'(v - 5'd30)};
    end else if (v >= 5'd20) begin
      r = {2'd2, 4'(v - 5'd20)};
    end else if (v >= 5'd10) begin
      r = {2'd1, 4'(v - 5'd10)};
    end else begin
      r = {2'd0, v[3:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/e2bcd_sub.sv =====
// ----------------------------------------------------------------------------
// e2bcd_sub
// Shared subtract and compare unit: difference and a >= b flag.
// ----------------------------------------------------------------------------
`default_nettype none

module e2bcd_sub
  import e2bcd_pkg::*;
(
  input  sub_req_t req,
  output sub_rsp_t rsp
);

  logic [OP_W:0] full;

  assign full     = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.diff = full[OP_W-1:0];
  assign rsp.ge   = ~full[OP_W];

endmodule

`default_nettype wire

// ===== rtl/core/epoch_to_bcd_datetime.sv =====
// ----------------------------------------------------------------------------
// epoch_to_bcd_datetime
// Seconds since 1970-01-01 to packed BCD calendar time, window 1970-2069.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | transfer
//  ---------+----------------------------------------+----------------------
//  input    | start, busy, in_epoch_seconds          | start && !busy
//  result   | out_valid, out_* fields                | out_valid, one cycle
//
//  a conversion takes the day count and remainders by reciprocal multiply
//  in S_DIV and S_REM, then a window check in S_CHK that ends it past the
//  window, otherwise on the shared subtractor up to 34 digit steps for the
//  time of day, up to 100 year steps and up to 12 month steps
//  synchronous active-low reset returns the sequencer to idle
//  results cannot be stalled; busy is low again in the strobe cycle
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_to_bcd_datetime
  import e2bcd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [IN_W-1:0] in_epoch_seconds,
  output logic                 out_valid,
  output logic [6:0]           out_second_bcd,
  output logic [6:0]           out_minute_bcd,
  output logic [5:0]           out_hour_bcd,
  output logic [2:0]           out_weekday,
  output logic [5:0]           out_day_bcd,
  output logic [4:0]           out_month_bcd,
  output logic [7:0]           out_year_bcd,
  output logic                 out_out_of_range
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_REM, S_CHK, S_H10, S_H1, S_M10, S_M1, S_S10, S_YEAR, S_MON
  } state_t;

  state_t state_r, state_nxt;

  logic [IN_W-1:0]   num_r, num_nxt;
  logic [TOD_W-1:0]  rem_r, rem_nxt;
  logic [DAYS_W-1:0] days_r, days_nxt;
  logic [WKQ_W-1:0]  wkq_r, wkq_nxt;
  logic [2:0]        wk_r, wk_nxt;
  logic [1:0]        hr_t_r, hr_t_nxt;
  logic [3:0]        hr_u_r, hr_u_nxt;
  logic [2:0]        mn_t_r, mn_t_nxt;
  logic [3:0]        mn_u_r, mn_u_nxt;
  logic [2:0]        sc_t_r, sc_t_nxt;
  logic [3:0]        sc_u_r, sc_u_nxt;
  logic [3:0]        yr_t_r, yr_t_nxt;
  logic [3:0]        yr_u_r, yr_u_nxt;
  logic [1:0]        yr_m4_r, yr_m4_nxt;
  logic [3:0]        mon_r, mon_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [6:0]        out_sec_r, out_sec_nxt;
  logic [6:0]        out_min_r, out_min_nxt;
  logic [5:0]        out_hour_r, out_hour_nxt;
  logic [2:0]        out_wday_r, out_wday_nxt;
  logic [5:0]        out_day_r, out_day_nxt;
  logic [4:0]        out_mon_r, out_mon_nxt;
  logic [7:0]        out_year_r, out_year_nxt;
  logic              out_oor_r, out_oor_nxt;

  sub_req_t sub_req;
  sub_rsp_t sub_rsp;
  logic     leap;

  logic [NUM_W-1:0]     day_num;
  logic [PROD_W-1:0]    day_prod;
  logic [NUM_W-1:0]     day_back;
  logic [NUM_W-1:0]     day_rem;
  logic [WK_PROD_W-1:0] wk_prod;
  logic [DAYS_W:0]      wk_sev;
  logic [DAYS_W:0]      wk_diff;

  e2bcd_sub u_sub (
    .req (sub_req),
    .rsp (sub_rsp)
  );

  assign leap = (yr_m4_r == 2'd0);

  assign day_num  = num_r[IN_W-1:DAY_SHIFT];
  assign day_prod = {{RECIP_W{1'b0}}, day_num} * {{NUM_W{1'b0}}, DAY_RECIP};
  assign day_back = {{(NUM_W-DAYS_W){1'b0}}, days_r} * {{(NUM_W-ODD_W){1'b0}}, DAY_ODD};
  assign day_rem  = day_num - day_back;
  assign wk_prod  = {{WK_RECIP_W{1'b0}}, days_r} * {{DAYS_W{1'b0}}, WK_RECIP};
  assign wk_sev   = {wkq_r, 3'd0} - {3'd0, wkq_r};
  assign wk_diff  = {1'b0, days_r} - wk_sev;

  always_comb begin
    logic [3:0] wk_sum;
    logic [5:0] mon_bcd;
    state_nxt     = state_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    days_nxt      = days_r;
    wkq_nxt       = wkq_r;
    wk_nxt        = wk_r;
    hr_t_nxt      = hr_t_r;
    hr_u_nxt      = hr_u_r;
    mn_t_nxt      = mn_t_r;
    mn_u_nxt      = mn_u_r;
    sc_t_nxt      = sc_t_r;
    sc_u_nxt      = sc_u_r;
    yr_t_nxt      = yr_t_r;
    yr_u_nxt      = yr_u_r;
    yr_m4_nxt     = yr_m4_r;
    mon_nxt       = mon_r;
    out_valid_nxt = 1'b0;
    out_sec_nxt   = out_sec_r;
    out_min_nxt   = out_min_r;
    out_hour_nxt  = out_hour_r;
    out_wday_nxt  = out_wday_r;
    out_day_nxt   = out_day_r;
    out_mon_nxt   = out_mon_r;
    out_year_nxt  = out_year_r;
    out_oor_nxt   = out_oor_r;
    sub_req.a     = '0;
    sub_req.b     = '0;
    wk_sum        = {1'b0, wk_r} + {1'b0, EPOCH_WEEKDAY};
    mon_bcd       = small_bcd(5'(mon_r) + 5'd1);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          num_nxt   = in_epoch_seconds;
          rem_nxt   = '0;
          wk_nxt    = '0;
          hr_t_nxt  = '0;
          hr_u_nxt  = '0;
          mn_t_nxt  = '0;
          mn_u_nxt  = '0;
          sc_t_nxt  = '0;
          sc_u_nxt  = '0;
          yr_t_nxt  = FIRST_YEAR_TENS;
          yr_u_nxt  = FIRST_YEAR_UNITS;
          yr_m4_nxt = FIRST_YEAR_MOD4;
          mon_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        days_nxt  = day_prod[RECIP_SHIFT +: DAYS_W];
        state_nxt = S_REM;
      end
      S_REM: begin
        rem_nxt   = {day_rem[ODD_W-1:0], num_r[DAY_SHIFT-1:0]};
        wkq_nxt   = wk_prod[WK_SHIFT +: WKQ_W];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        sub_req.a = {{(OP_W-DAYS_W){1'b0}}, days_r};
        sub_req.b = DAYS_IN_WINDOW;
        wk_nxt    = wk_diff[2:0];
        if (sub_rsp.ge) begin
          out_valid_nxt = 1'b1;
          out_sec_nxt   = '0;
          out_min_nxt   = '0;
          out_hour_nxt  = '0;
          out_wday_nxt  = '0;
          out_day_nxt   = '0;
          out_mon_nxt   = '0;
          out_year_nxt  = '0;
          out_oor_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_H10;
        end
      end
      S_H10, S_H1, S_M10, S_M1, S_S10: begin
        sub_req.a = {1'b0, rem_r};
        case (state_r)
          S_H10:   sub_req.b = SECS_10_HOURS;
          S_H1:    sub_req.b = SECS_PER_HOUR;
          S_M10:   sub_req.b = SECS_10_MINS;
          S_M1:    sub_req.b = SECS_PER_MIN;
          default: sub_req.b = SECS_TEN;
        endcase
        if (sub_rsp.ge) begin
          rem_nxt = sub_rsp.diff[TOD_W-1:0];
          case (state_r)
            S_H10:   hr_t_nxt = hr_t_r + 1'b1;
            S_H1:    hr_u_nxt = hr_u_r + 1'b1;
            S_M10:   mn_t_nxt = mn_t_r + 1'b1;
            S_M1:    mn_u_nxt = mn_u_r + 1'b1;
            default: sc_t_nxt = sc_t_r + 1'b1;
          endcase
        end else begin
          case (state_r)
            S_H10:   state_nxt = S_H1;
            S_H1:    state_nxt = S_M10;
            S_M10:   state_nxt = S_M1;
            S_M1:    state_nxt = S_S10;
            default: begin
              sc_u_nxt  = rem_r[3:0];
              state_nxt = S_YEAR;
            end
          endcase
        end
      end
      S_YEAR: begin
        sub_req.a = {{(OP_W-DAYS_W){1'b0}}, days_r};
        sub_req.b = leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
        if (sub_rsp.ge) begin
          days_nxt  = sub_rsp.diff[DAYS_W-1:0];
          yr_m4_nxt = yr_m4_r + 1'b1;
          if (yr_u_r == 4'd9) begin
            yr_u_nxt = '0;
            yr_t_nxt = (yr_t_r == 4'd9) ? 4'd0 : yr_t_r + 1'b1;
          end else begin
            yr_u_nxt = yr_u_r + 1'b1;
          end
        end else begin
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        sub_req.a = {{(OP_W-DAYS_W){1'b0}}, days_r};
        sub_req.b = month_len(mon_r, leap);
        if (!sub_rsp.ge || mon_r == LAST_MONTH) begin
          out_valid_nxt = 1'b1;
          out_sec_nxt   = {sc_t_r, sc_u_r};
          out_min_nxt   = {mn_t_r, mn_u_r};
          out_hour_nxt  = {hr_t_r, hr_u_r};
          out_wday_nxt  = (wk_sum >= 4'd7) ? 3'(wk_sum - 4'd7) : wk_sum[2:0];
          out_day_nxt   = small_bcd(days_r[4:0] + 5'd1);
          out_mon_nxt   = mon_bcd[4:0];
          out_year_nxt  = {yr_t_r, yr_u_r};
          out_oor_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          days_nxt = sub_rsp.diff[DAYS_W-1:0];
          mon_nxt  = mon_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    days_r     <= days_nxt;
    wkq_r      <= wkq_nxt;
    wk_r       <= wk_nxt;
    hr_t_r     <= hr_t_nxt;
    hr_u_r     <= hr_u_nxt;
    mn_t_r     <= mn_t_nxt;
    mn_u_r     <= mn_u_nxt;
    sc_t_r     <= sc_t_nxt;
    sc_u_r     <= sc_u_nxt;
    yr_t_r     <= yr_t_nxt;
    yr_u_r     <= yr_u_nxt;
    yr_m4_r    <= yr_m4_nxt;
    mon_r      <= mon_nxt;
    out_sec_r  <= out_sec_nxt;
    out_min_r  <= out_min_nxt;
    out_hour_r <= out_hour_nxt;
    out_wday_r <= out_wday_nxt;
    out_day_r  <= out_day_nxt;
    out_mon_r  <= out_mon_nxt;
    out_year_r <= out_year_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_second_bcd   = out_sec_r;
  assign out_minute_bcd   = out_min_r;
  assign out_hour_bcd     = out_hour_r;
  assign out_weekday      = out_wday_r;
  assign out_day_bcd      = out_day_r;
  assign out_month_bcd    = out_mon_r;
  assign out_year_bcd     = out_year_r;
  assign out_out_of_range = out_oor_r;

endmodule

`default_nettype wire

// ===== rtl/core/e2bcd_checker.sv =====
// ----------------------------------------------------------------------------
// e2bcd_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module e2bcd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [6:0] out_second_bcd,
  input wire logic [6:0] out_minute_bcd,
  input wire logic [5:0] out_hour_bcd,
  input wire logic [2:0] out_weekday,
  input wire logic [5:0] out_day_bcd,
  input wire logic [4:0] out_month_bcd,
  input wire logic [7:0] out_year_bcd,
  input wire logic       out_out_of_range
);

  // a transfer in starts a conversion
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after input transfer");

  // the result strobe comes exactly when busy falls
  a_fell_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("conversion ended without result");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside end of conversion");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_second_bcd == 7'd0 && out_minute_bcd == 7'd0 &&
      out_hour_bcd == 6'd0 && out_weekday == 3'd0 && out_day_bcd == 6'd0 &&
      out_month_bcd == 5'd0 && out_year_bcd == 8'd0)
    else $error("fields not cleared past the window");

  a_bcd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |-> out_second_bcd[3:0] <= 4'd9 &&
      out_second_bcd[6:4] <= 3'd5 && out_minute_bcd[3:0] <= 4'd9 &&
      out_minute_bcd[6:4] <= 3'd5 && out_weekday <= 3'd6 && out_day_bcd != 6'd0 &&
      out_month_bcd != 5'd0 && out_year_bcd[3:0] <= 4'd9)
    else $error("result field out of range");

endmodule

bind epoch_to_bcd_datetime e2bcd_checker u_e2bcd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_second_bcd   (out_second_bcd),
  .out_minute_bcd   (out_minute_bcd),
  .out_hour_bcd     (out_hour_bcd),
  .out_weekday      (out_weekday),
  .out_day_bcd      (out_day_bcd),
  .out_month_bcd    (out_month_bcd),
  .out_year_bcd     (out_year_bcd),
  .out_out_of_range (out_out_of_range)
);

`default_nettype wire
